### design/rslt_pkg.sv
`default_nettype none
package rslt_pkg;
  localparam int MapWords = 4096;
  localparam int MapAddrW = 12;
  localparam int HalfWords = 2048;
  localparam logic [31:0] SeqSpan = 32'd65536;
  localparam logic [31:0] DesyncGap = 32'd536;
  localparam logic [31:0] WrapLimit = 32'd65000;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_RESET   = 3'd1,
    ST_DESYNC  = 3'd2,
    ST_DUP     = 3'd3,
    ST_ADVANCE = 3'd4,
    ST_LATE    = 3'd5,
    ST_NEWMIN  = 3'd6,
    ST_ERROR   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DECIDE, S_READ, S_UPDATE, S_CLEAR, S_OUT
  } fsm_t;

  // clear sweep kinds
  typedef enum logic [1:0] {
    CLR_NONE, CLR_ALL, CLR_LOW, CLR_HIGH
  } clr_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic rd;
    logic update;
    logic clr_step;
    logic clr_start;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_clear;
    logic need_read;
    logic clr_done;
  } sts_t;
endpackage
`default_nettype wire

### design/rslt_ctrl.sv
`default_nettype none
module rslt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic            out_busy,
  input  wire rslt_pkg::sts_t  sts,
  output rslt_pkg::cmd_t       cmd,
  output logic                 in_ready
);
  import rslt_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:   if (in_fire) state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.need_clear) state_next = S_CLEAR;
        else state_next = S_READ;
      end
      S_CLEAR:  if (sts.clr_done) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_OUT;
      S_OUT:    if (!out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_INIT:   cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_fire;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.clr_start = sts.need_clear;
      end
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_READ:   cmd.rd = 1'b1;
      S_UPDATE: cmd.update = 1'b1;
      S_OUT:    cmd.load_out = !out_busy;
      default:  cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

### design/rslt_dp.sv
`default_nettype none
module rslt_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rslt_pkg::cmd_t  cmd,
  input  wire logic [31:0]     in_src,
  input  wire logic [15:0]     in_seq,
  input  wire logic            in_mark,
  output rslt_pkg::sts_t       sts,
  output logic [2:0]           status,
  output logic [31:0]          total_sent,
  output logic [31:0]          total_received,
  output logic [31:0]          total_duplicates,
  output logic [31:0]          source_changes,
  output logic [31:0]          reset_count,
  output logic [31:0]          desyncs,
  output logic [31:0]          window_packets,
  output logic [31:0]          window_highest,
  output logic [31:0]          window_lowest,
  output logic [31:0]          window_dups
);
  import rslt_pkg::*;

  logic [31:0] mem [MapWords];
  logic [31:0] rd_data;

  logic [31:0] src_r, raw_r;
  logic        mark_r;
  logic [31:0] cur_src, hi, lo, woff, pkts, dups, sent, recv, dsum, scc, src_cnt, dcnt;
  logic [31:0] s_r;
  logic        open_r;     // window opens with this packet
  logic [2:0]  st_r;
  logic        done_r;     // status already final before bitmap lookup

  // clear sweep
  logic [MapAddrW:0] clr_cnt;
  logic [MapAddrW:0] clr_end;
  logic              pre_clear;

  // decide stage: combinational classification
  logic [31:0] s_ext;
  logic        first, chg, sreset, prewrap, wrap, dsync;
  always_comb begin
    s_ext   = raw_r + woff;
    first   = (scc == 32'd0);
    chg     = !first && (cur_src != src_r);
    sreset  = !first && !chg && mark_r && (s_ext < hi) && (hi[15:0] != 16'hffff);
    prewrap = (hi[15:0] < DesyncGap[15:0]) && (raw_r > WrapLimit);
    wrap    = !prewrap && (hi > WrapLimit) && (s_ext < hi - WrapLimit);
    dsync   = !prewrap && !wrap &&
              ((s_ext + DesyncGap < hi) || (s_ext > hi + DesyncGap));
  end

  logic any_close;
  assign any_close = chg || sreset || (!first && !chg && !sreset && dsync);
  logic wrap_go;
  assign wrap_go = !first && !chg && !sreset && wrap;
  logic [31:0] woff_new;
  assign woff_new = woff + SeqSpan;

  assign sts.need_clear = any_close || wrap_go;
  assign sts.need_read  = 1'b1;
  assign sts.clr_done   = (clr_cnt == clr_end);

  logic [MapAddrW-1:0] rd_addr;
  logic [4:0]          bit_ix;
  assign rd_addr = s_r[16:5];
  assign bit_ix  = s_r[4:0];

  // bitmap memory: one write port, registered read
  logic                wr_en;
  logic [MapAddrW-1:0] wr_addr;
  logic [31:0]         wr_data;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_addr;
    wr_data = '0;
    if (cmd.clr_step && !sts.clr_done) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[MapAddrW-1:0];
    end else if (cmd.update && !(!open_r && !done_r && rd_data[bit_ix])) begin
      wr_en = !done_r || open_r;
      wr_data = (open_r ? ((pre_clear) ? 32'd0 : rd_data) : rd_data)
                | (32'd1 << bit_ix);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[rd_addr];
  end

  // sequencing of one packet
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_src <= '0; hi <= '0; lo <= '0; woff <= '0; pkts <= '0; dups <= '0;
      sent <= '0; recv <= '0; dsum <= '0; scc <= '0; src_cnt <= '0; dcnt <= '0;
      // full bitmap sweep right after reset
      clr_cnt <= '0; clr_end <= (MapAddrW+1)'(MapWords);
    end else begin
      if (cmd.capture) begin
        src_r <= in_src;
        raw_r <= {16'd0, in_seq};
        mark_r <= in_mark;
      end
      if (cmd.decide) begin
        pre_clear <= 1'b0;
        open_r <= 1'b0;
        done_r <= 1'b0;
        if (first) begin
          cur_src <= src_r;
          scc <= 32'd1;
          s_r <= raw_r;
          open_r <= 1'b1;
          st_r <= ST_START;
        end else if (any_close) begin
          if (pkts != 32'd0) begin
            sent <= sent + (hi - lo + 32'd1);
            recv <= recv + pkts;
            dsum <= dsum + dups;
          end
          dups <= '0;
          open_r <= 1'b1;
          clr_cnt <= '0;
          clr_end <= (MapAddrW+1)'(MapWords);
          if (chg) begin
            cur_src <= src_r; scc <= scc + 32'd1; s_r <= raw_r; st_r <= ST_START;
          end else if (sreset) begin
            src_cnt <= src_cnt + 32'd1; s_r <= s_ext; st_r <= ST_RESET;
          end else begin
            dcnt <= dcnt + 32'd1; s_r <= s_ext; st_r <= ST_DESYNC;
          end
        end else begin
          if (prewrap) s_r <= s_ext - SeqSpan;
          else if (wrap) begin
            woff <= woff_new;
            s_r <= s_ext + SeqSpan;
            if (woff_new[16]) begin
              clr_cnt <= (MapAddrW+1)'(HalfWords);
              clr_end <= (MapAddrW+1)'(MapWords);
            end else begin
              clr_cnt <= '0;
              clr_end <= (MapAddrW+1)'(HalfWords);
            end
          end else s_r <= s_ext;
        end
      end
      if (cmd.clr_step && !sts.clr_done) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.update) begin
        if (open_r) begin
          hi <= s_r; lo <= s_r; pkts <= 32'd1;
        end else if (rd_data[bit_ix]) begin
          dups <= dups + 32'd1; st_r <= ST_DUP;
        end else if (s_r >= hi) begin
          hi <= s_r; pkts <= pkts + 32'd1; st_r <= ST_ADVANCE;
        end else if (s_r >= lo) begin
          pkts <= pkts + 32'd1; st_r <= ST_LATE;
        end else if (woff == 32'd0) begin
          lo <= s_r; pkts <= pkts + 32'd1; st_r <= ST_NEWMIN;
        end else st_r <= ST_ERROR;
      end
      if (cmd.load_out) begin
        status <= st_r;
        total_sent <= sent; total_received <= recv; total_duplicates <= dsum;
        source_changes <= scc; reset_count <= src_cnt; desyncs <= dcnt;
        window_packets <= pkts; window_highest <= hi; window_lowest <= lo;
        window_dups <= dups;
      end
    end
  end
endmodule
`default_nettype wire

### design/rtp_sequence_loss_tracker.sv
// Flow: each packet passes the decide, read, update and output states, with a bitmap
//   clear sweep (one word a cycle) first if a window closes or the sequence wraps.
// Input: a new packet is taken only after the last result is loaded for output;
//   the 4096 x 32 seen bitmap has one write port and a registered read.
// Reset: synchronous rst zeroes all counters and starts a sweep that zeroes all 4096
//   bitmap words; no input is taken until the sweep is done.
`default_nettype none
module rtp_sequence_loss_tracker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,   // source_id[31:0], sequence_req[47:32]
  input  wire logic         s_tuser,   // marker
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [327:0]      m_tdata    // status[2:0], total_sent .. window_dups, 5 pad
);
  import rslt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;
  logic [2:0]  status;
  logic [31:0] t_sent, t_recv, t_dup, s_chg, r_cnt, d_cnt, w_pk, w_hi, w_lo, w_dup;

  assign in_fire = s_tvalid && s_tready;

  rslt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
    .sts(sts), .cmd(cmd), .in_ready(s_tready)
  );

  rslt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_src(s_tdata[31:0]), .in_seq(s_tdata[47:32]), .in_mark(s_tuser),
    .sts(sts), .status(status), .total_sent(t_sent), .total_received(t_recv),
    .total_duplicates(t_dup), .source_changes(s_chg), .reset_count(r_cnt),
    .desyncs(d_cnt), .window_packets(w_pk), .window_highest(w_hi),
    .window_lowest(w_lo), .window_dups(w_dup)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {5'd0, w_dup, w_lo, w_hi, w_pk, d_cnt, r_cnt, s_chg,
                    t_dup, t_recv, t_sent, status};
endmodule
`default_nettype wire

### tb/tb_checker.sv
`default_nettype none
module tb_checker
  import rslt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [47:0]  s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [327:0] m_tdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] wdups;
    logic [31:0] wlow;
    logic [31:0] whigh;
    logic [31:0] wpkts;
    logic [31:0] desyncs;
    logic [31:0] resets;
    logic [31:0] srcchg;
    logic [31:0] tdups;
    logic [31:0] trcv;
    logic [31:0] tsent;
    status_t     status;
  } report_t;

  // tracker state mirror
  logic [31:0] seen_map [MapWords];
  logic [31:0] cur_src, hi_seq, lo_seq, wrap_off, win_pkts, win_dups;
  logic [31:0] sent_acc, rcv_acc, dup_acc, src_chg, seq_resets, desync_cnt;
  report_t     expected_reports[$];

  function automatic logic seen(input logic [31:0] s);
    return seen_map[s[16:5]][s[4:0]];
  endfunction

  function automatic void close_win();
    if (win_pkts != 0) begin
      sent_acc = sent_acc + (hi_seq - lo_seq + 32'd1);
      rcv_acc  = rcv_acc + win_pkts;
      dup_acc  = dup_acc + win_dups;
    end
    win_dups = 0;
    foreach (seen_map[i]) seen_map[i] = '0;
  endfunction

  function automatic void open_win(input logic [31:0] s);
    hi_seq = s;
    lo_seq = s;
    win_pkts = 1;
    seen_map[s[16:5]][s[4:0]] = 1'b1;
  endfunction

  function automatic status_t track_packet(input logic [31:0] src, input logic [15:0] raw,
                                           input logic mark);
    logic [31:0] s;
    s = {16'd0, raw};
    if (src_chg == 0) begin
      cur_src = src;
      open_win(s);
      src_chg = 1;
      return ST_START;
    end
    if (cur_src != src) begin
      close_win();
      cur_src = src;
      open_win(s);
      src_chg = src_chg + 32'd1;
      return ST_START;
    end
    s = s + wrap_off;
    if (mark && s < hi_seq && hi_seq[15:0] != 16'hffff) begin
      close_win();
      open_win(s);
      seq_resets = seq_resets + 32'd1;
      return ST_RESET;
    end
    if (hi_seq[15:0] < DesyncGap && {16'd0, raw} > WrapLimit) begin
      s = s - SeqSpan;
    end else if (hi_seq > WrapLimit && s < hi_seq - WrapLimit) begin
      wrap_off = wrap_off + SeqSpan;
      s = s + SeqSpan;
      // clear the half the next span will use
      for (int i = 0; i < HalfWords; i++)
        seen_map[wrap_off[16] ? i + HalfWords : i] = '0;
    end else if (s + DesyncGap < hi_seq || s > hi_seq + DesyncGap) begin
      close_win();
      open_win(s);
      desync_cnt = desync_cnt + 32'd1;
      return ST_DESYNC;
    end
    if (seen(s)) begin
      win_dups = win_dups + 32'd1;
      return ST_DUP;
    end
    seen_map[s[16:5]][s[4:0]] = 1'b1;
    if (s >= hi_seq) begin
      hi_seq = s;
      win_pkts = win_pkts + 32'd1;
      return ST_ADVANCE;
    end
    if (s >= lo_seq) begin
      win_pkts = win_pkts + 32'd1;
      return ST_LATE;
    end
    if (wrap_off == 0) begin
      lo_seq = s;
      win_pkts = win_pkts + 32'd1;
      return ST_NEWMIN;
    end
    return ST_ERROR;
  endfunction

  task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0d actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  assign pending = expected_reports.size();

  always @(posedge clk) begin
    report_t r, got;
    if (rst) begin
      foreach (seen_map[i]) seen_map[i] = '0;
      {cur_src, hi_seq, lo_seq, wrap_off, win_pkts, win_dups} = '0;
      {sent_acc, rcv_acc, dup_acc, src_chg, seq_resets, desync_cnt} = '0;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        r.status  = track_packet(s_tdata[31:0], s_tdata[47:32], s_tuser);
        r.tsent   = sent_acc;
        r.trcv    = rcv_acc;
        r.tdups   = dup_acc;
        r.srcchg  = src_chg;
        r.resets  = seq_resets;
        r.desyncs = desync_cnt;
        r.wpkts   = win_pkts;
        r.whigh   = hi_seq;
        r.wlow    = lo_seq;
        r.wdups   = win_dups;
        expected_reports.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[322:0];
        if (expected_reports.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          r = expected_reports.pop_front();
          cmp("status", 32'(r.status), 32'(got.status));
          cmp("total_sent", r.tsent, got.tsent);
          cmp("total_received", r.trcv, got.trcv);
          cmp("total_duplicates", r.tdups, got.tdups);
          cmp("source_changes", r.srcchg, got.srcchg);
          cmp("reset_count", r.resets, got.resets);
          cmp("desyncs", r.desyncs, got.desyncs);
          cmp("window_packets", r.wpkts, got.wpkts);
          cmp("window_highest", r.whigh, got.whigh);
          cmp("window_lowest", r.wlow, got.wlow);
          cmp("window_dups", r.wdups, got.wdups);
        end
      end
    end
  end
endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 40_000_000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // source_id[31:0], sequence_req[47:32]
  logic         s_tuser = 1'b0; // marker
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [327:0] m_tdata;        // status, totals, window counters
  int           fail_count, pending;
  int           send_idle_pct = 0, recv_stall_pct = 0;
  int           hold_cycles = 0;
  int           cycles = 0;

  // stream identity the random packets follow
  logic [31:0]  cur_ssrc = 32'h1234_5678;
  logic [15:0]  next_seq = 16'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtp_sequence_loss_tracker dut (.*);

  tb_checker chk (.*);

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up between back-to-back packets; it drops only while idling
  task automatic send_packet(input logic [31:0] src, input logic [15:0] seq, input logic mark);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seq, src};
    s_tuser  <= mark;
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly in-window traffic, with occasional dups, late, jumps, resets, new sources
  task automatic send_random();
    int k;
    logic [15:0] seq;
    k = $urandom_range(99);
    if (k < 60) begin
      seq = next_seq + 16'($urandom_range(3));
      next_seq = seq + 16'd1;
    end else if (k < 75) begin
      seq = next_seq - 16'($urandom_range(40));
    end else if (k < 82) begin
      seq = next_seq - 16'($urandom_range(600));
      send_packet(cur_ssrc, seq, 1'b1);
      return;
    end else if (k < 88) begin
      seq = 16'($urandom);
      next_seq = seq + 16'd1;
    end else if (k < 92) begin
      cur_ssrc = ($urandom_range(1)) ? $urandom : cur_ssrc ^ 32'h1;
      seq = 16'($urandom);
      next_seq = seq + 16'd1;
    end else begin
      // ride toward a wrap
      seq = 16'(65530 + $urandom_range(5));
      next_seq = seq + 16'd1;
    end
    send_packet(cur_ssrc, seq, $urandom_range(9) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: start, advance, dup, late, new minimum, seq reset, desync, wrap, source change
    send_packet(32'hffff_ffff, 16'd100, 1'b0);
    send_packet(32'hffff_ffff, 16'd101, 1'b0);
    send_packet(32'hffff_ffff, 16'd101, 1'b0);
    send_packet(32'hffff_ffff, 16'd104, 1'b0);
    send_packet(32'hffff_ffff, 16'd102, 1'b0);
    send_packet(32'hffff_ffff, 16'd90, 1'b0);
    send_packet(32'hffff_ffff, 16'd50, 1'b1);
    send_packet(32'hffff_ffff, 16'd5000, 1'b0);
    send_packet(32'hffff_ffff, 16'd0, 1'b0);
    send_packet(32'h0000_0000, 16'd65200, 1'b0);
    send_packet(32'h0000_0000, 16'd65535, 1'b0);
    send_packet(32'h0000_0000, 16'd65535, 1'b1);
    send_packet(32'h0000_0000, 16'd3, 1'b0);
    send_packet(32'h0000_0000, 16'd65534, 1'b0);
    send_packet(32'h0000_0000, 16'd65001, 1'b0);
    send_packet(32'h0000_0000, 16'd10, 1'b0);
    send_packet(32'h0000_0000, 16'd400, 1'b0);
    send_packet(32'h0000_0000, 16'd2, 1'b1);
    send_packet(32'h5555_aaaa, 16'h5555, 1'b1);
    send_packet(32'haaaa_5555, 16'haaaa, 1'b0);

    // long receiver hold while the sender keeps offering
    hold_cycles = 300;
    for (int i = 0; i < 30; i++) send_random();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int i = 0; i < 375; i++) send_random();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
